### src/lpht_pkg.sv
// Shared types and constants for the layer point hit test block.
// No dependencies; used by the layer store, the match unit, the top level and the checker.
package lpht_pkg;

    // Default number of layer slots
    localparam int LAYERS_DEF = 32;

    // Operation codes carried on the operation input
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Field widths fixed by the interface
    localparam int SLOT_W  = 5;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 13;
    localparam int Z_W     = 16;
    localparam int TAG_W   = 16;

    // One stored layer slot
    typedef struct packed {
        logic               present;
        logic               shown;
        logic               touchable;
        logic               has_tag;
        logic [TAG_W-1:0]   tag;
        logic [Z_W-1:0]     z;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
    } layer_entry_t;

endpackage

### src/layer_point_hit_test_unit.sv
// Layer point hit test: a write transaction returns an all-zero result in the next
// cycle; a query transaction scans every slot through the single read port of the
// layer store, one slot per cycle, then folds in the last slot read in a drain
// state and forms the result in a done state, after which the next transaction
// can be taken. The input stalls while a query scans and while a result waits on
// a stalled output. Slots start absent after reset with no clearing pass; writes
// to slots at or beyond LAYERS are dropped.
// Depends on lpht_pkg, lpht_layer_mem and lpht_match_unit.
module layer_point_hit_test_unit #(
    parameter int LAYERS = lpht_pkg::LAYERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [4:0]  slot,
    input  logic        present,
    input  logic        shown,
    input  logic        touchable,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic [12:0] rect_width,
    input  logic [12:0] rect_height,
    input  logic signed [15:0] depth_z,
    input  logic [15:0] tag,
    input  logic        has_tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [15:0] hit_tag,
    output logic [4:0]  hit_slot
);

    localparam int IDX_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAYERS - 1);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [15:0]      px_reg, px_next;
    logic [15:0]      py_reg, py_next;
    logic             best_found_reg, best_found_next;
    logic [15:0]      best_z_reg, best_z_next;
    logic [IDX_W-1:0] best_slot_reg, best_slot_next;
    logic [15:0]      best_tag_reg, best_tag_next;
    logic             best_has_tag_reg, best_has_tag_next;
    logic             out_valid_reg, out_valid_next;
    logic             hit_reg, hit_next;
    logic [15:0]      hit_tag_reg, hit_tag_next;
    logic [4:0]       hit_slot_reg, hit_slot_next;

    logic                   in_take;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    lpht_pkg::layer_entry_t wr_entry;
    logic                   rd_en;
    lpht_pkg::layer_entry_t rd_entry;
    logic                   take;

    // Input handshake
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_take  = in_valid && !in_stall;

    // Slot write straight from the accepted transaction
    assign wr_en   = in_take && (operation == lpht_pkg::OP_WRITE) && (32'(slot) < LAYERS);
    assign wr_addr = IDX_W'(slot);

    always_comb
    begin
        wr_entry.present   = present;
        wr_entry.shown     = shown;
        wr_entry.touchable = touchable;
        wr_entry.has_tag   = has_tag;
        wr_entry.tag       = tag;
        wr_entry.z         = depth_z;
        wr_entry.x         = coord_x;
        wr_entry.y         = coord_y;
        wr_entry.w         = rect_width;
        wr_entry.h         = rect_height;
    end

    assign rd_en = (state_reg == S_SCAN);

    lpht_layer_mem #(
        .LAYERS (LAYERS),
        .IDX_W  (IDX_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (cnt_reg),
        .rd_entry (rd_entry)
    );

    lpht_match_unit u_match (
        .entry      (rd_entry),
        .px         (px_reg),
        .py         (py_reg),
        .best_found (best_found_reg),
        .best_z     (best_z_reg),
        .take       (take)
    );

    // Sequencer, best-candidate tracking and result register
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        rd_idx_next       = rd_idx_reg;
        rd_vld_next       = 1'b0;
        px_next           = px_reg;
        py_next           = py_reg;
        best_found_next   = best_found_reg;
        best_z_next       = best_z_reg;
        best_slot_next    = best_slot_reg;
        best_tag_next     = best_tag_reg;
        best_has_tag_next = best_has_tag_reg;
        out_valid_next    = out_valid_reg;
        hit_next          = hit_reg;
        hit_tag_next      = hit_tag_reg;
        hit_slot_next     = hit_slot_reg;

        // Result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Fold the slot read last cycle into the running best
        if (rd_vld_reg && take)
        begin
            best_found_next   = 1'b1;
            best_z_next       = rd_entry.z;
            best_slot_next    = rd_idx_reg;
            best_tag_next     = rd_entry.tag;
            best_has_tag_next = rd_entry.has_tag;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (operation == lpht_pkg::OP_WRITE)
                    begin
                        out_valid_next = 1'b1;
                        hit_next       = 1'b0;
                        hit_tag_next   = '0;
                        hit_slot_next  = '0;
                    end
                    else
                    begin
                        px_next         = coord_x;
                        py_next         = coord_y;
                        cnt_next        = '0;
                        best_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_vld_next = 1'b1;
                rd_idx_next = cnt_reg;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                if (best_found_reg && best_has_tag_reg)
                begin
                    hit_next      = 1'b1;
                    hit_tag_next  = best_tag_reg;
                    hit_slot_next = 5'(best_slot_reg);
                end
                else
                begin
                    hit_next      = 1'b0;
                    hit_tag_next  = '0;
                    hit_slot_next = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_vld_reg     <= rd_vld_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg       <= rd_idx_next;
        px_reg           <= px_next;
        py_reg           <= py_next;
        best_z_reg       <= best_z_next;
        best_slot_reg    <= best_slot_next;
        best_tag_reg     <= best_tag_next;
        best_has_tag_reg <= best_has_tag_next;
        hit_reg          <= hit_next;
        hit_tag_reg      <= hit_tag_next;
        hit_slot_reg     <= hit_slot_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_tag   = hit_tag_reg;
    assign hit_slot  = hit_slot_reg;

endmodule

### src/lpht_layer_mem.sv
// Layer slot store: one write port, one registered read port, per-slot valid bits.
// Depends on lpht_pkg for the entry type.
module lpht_layer_mem #(
    parameter int LAYERS = lpht_pkg::LAYERS_DEF,
    parameter int IDX_W  = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  lpht_pkg::layer_entry_t wr_entry,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output lpht_pkg::layer_entry_t rd_entry
);

    lpht_pkg::layer_entry_t mem [LAYERS];
    lpht_pkg::layer_entry_t rd_data_reg;
    logic [LAYERS-1:0]      valid_reg;
    logic                   rd_present_reg;

    // Slot contents, no reset; absent slots are masked by the valid bits
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Presence bits, cleared at reset so every slot starts absent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_present_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= wr_entry.present;
            end
            if (rd_en)
            begin
                rd_present_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Presence comes from the valid bit, the rest from the array
    always_comb
    begin
        rd_entry         = rd_data_reg;
        rd_entry.present = rd_present_reg;
    end

endmodule

### src/lpht_match_unit.sv
// Shared compare unit: tests one layer against the probe point and the current best.
// Depends on lpht_pkg for the entry type and field widths.
module lpht_match_unit (
    input  lpht_pkg::layer_entry_t           entry,
    input  logic [lpht_pkg::COORD_W-1:0]     px,
    input  logic [lpht_pkg::COORD_W-1:0]     py,
    input  logic                             best_found,
    input  logic [lpht_pkg::Z_W-1:0]         best_z,
    output logic                             take
);

    logic signed [17:0] px_e;
    logic signed [17:0] py_e;
    logic signed [17:0] lx_e;
    logic signed [17:0] ty_e;
    logic signed [17:0] rx_e;
    logic signed [17:0] by_e;
    logic               in_x;
    logic               in_y;
    logic               z_ge;
    logic               eligible;

    // Sign-extend edges and point, form the exclusive right/bottom edges
    always_comb
    begin
        px_e = $signed({{2{px[15]}}, px});
        py_e = $signed({{2{py[15]}}, py});
        lx_e = $signed({{2{entry.x[15]}}, entry.x});
        ty_e = $signed({{2{entry.y[15]}}, entry.y});
        rx_e = lx_e + $signed({5'b0, entry.w});
        by_e = ty_e + $signed({5'b0, entry.h});
    end

    // Half-open containment, flags and depth priority (ties go to the later slot)
    always_comb
    begin
        in_x     = (px_e >= lx_e) && (px_e < rx_e);
        in_y     = (py_e >= ty_e) && (py_e < by_e);
        z_ge     = $signed(entry.z) >= $signed(best_z);
        eligible = entry.present && entry.shown && entry.touchable;
        take     = eligible && in_x && in_y && (!best_found || z_ge);
    end

endmodule

### src/lpht_checker.sv
// Port-level checks for the layer point hit test block, bound to the top level.
// Depends on lpht_pkg for the operation codes.
module lpht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        operation,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic [15:0] hit_tag,
    input logic [4:0]  hit_slot
);

    // A stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_tag)
            && $stable(hit_slot))
        else $error("stalled result changed");

    // No hit reports zero tag and zero slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_tag == 16'd0 && hit_slot == 5'd0)
        else $error("miss carries nonzero tag or slot");

    // A write transaction gets its no-hit result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == lpht_pkg::OP_WRITE |=> out_valid && !hit)
        else $error("write result missing or shows a hit");

    // A query keeps the input stalled and the output empty as its scan starts
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == lpht_pkg::OP_QUERY |=> in_stall && !out_valid)
        else $error("query scan not holding off input or output");

endmodule

bind layer_point_hit_test_unit lpht_checker u_lpht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .hit_tag   (hit_tag),
    .hit_slot  (hit_slot)
);
